FILE: design/twcol_pkg.sv
// ----------------------------------------------------------------------------
// twcol_pkg
// Shared types and constants of the textured wall column pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

package twcol_pkg;

  // Opcodes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_PLAYER_X = 2'd0;
  localparam logic [1:0] REG_PLAYER_Y = 2'd1;
  localparam logic [1:0] REG_SCREEN_W = 2'd2;
  localparam logic [1:0] REG_SCREEN_H = 2'd3;

  // Texture codes.
  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_WEST  = 2'd2;
  localparam logic [1:0] TEX_EAST  = 2'd3;

  // Per-channel halving mask for y-side shading.
  localparam logic [23:0] HALF_MASK = 24'h7F7F7F;

  // Sideband that travels beside the row divider.
  typedef struct packed {
    logic        op;
    logic        side;
    logic [1:0]  tex;
    logic [7:0]  tx;
    logic [13:0] tidx;
    logic [23:0] tcolor;
    logic [9:0]  row;
    logic [9:0]  col;
  } item_t;

endpackage

`default_nettype wire

FILE: design/twcol_ram.sv
// ----------------------------------------------------------------------------
// twcol_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module twcol_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/twcol_div.sv
// ----------------------------------------------------------------------------
// twcol_div
// Pipelined restoring divider for the texture row, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module twcol_div
  import twcol_pkg::*;
#(
  parameter int TB = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire item_t              item_i,
  input  wire logic signed [25:0] d_i,
  input  wire logic [15:0]        h_i,
  output logic                    valid_o,
  output item_t                   item_o,
  output logic [TB-1:0]           ty_o
);

  logic          v_q    [TB+1];
  item_t         it_q   [TB+1];
  logic [23:0]   rem_q  [TB+1];
  logic [23:0]   den_q  [TB+1];
  logic [TB-1:0] quo_q  [TB+1];
  logic          zero_q [TB+1];
  logic          clmp_q [TB+1];

  logic [23:0] den_d;
  logic        zero_d;
  logic        clmp_d;

  // Rows at or above the slice end clamp; nonpositive offsets give row zero.
  assign den_d  = {h_i, 8'b0};
  assign zero_d = (d_i <= 26'sd0);
  assign clmp_d = !zero_d && (d_i[24:0] >= {1'b0, den_d});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0]   <= item_i;
    rem_q[0]  <= d_i[23:0];
    den_q[0]  <= den_d;
    quo_q[0]  <= '0;
    zero_q[0] <= zero_d;
    clmp_q[0] <= clmp_d;
  end

  for (genvar k = 0; k < TB; k++) begin : g_stage
    logic [24:0] r2;
    logic        ge;
    logic [24:0] diff;
    assign r2   = {rem_q[k], 1'b0};
    assign ge   = (r2 >= {1'b0, den_q[k]});
    assign diff = r2 - {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k+1]   <= it_q[k];
      rem_q[k+1]  <= ge ? diff[23:0] : r2[23:0];
      den_q[k+1]  <= den_q[k];
      quo_q[k+1]  <= TB'({quo_q[k], ge});
      zero_q[k+1] <= zero_q[k];
      clmp_q[k+1] <= clmp_q[k];
    end
  end

  assign valid_o = v_q[TB];
  assign item_o  = it_q[TB];
  assign ty_o    = clmp_q[TB] ? {TB{1'b1}} : (zero_q[TB] ? '0 : quo_q[TB]);

endmodule

`default_nettype wire

FILE: design/textured_wall_column_pixel_core.sv
// ----------------------------------------------------------------------------
// textured_wall_column_pixel_core
// Raycaster wall pixel shader with four on-chip wall textures.
// ----------------------------------------------------------------------------
// The core takes one item per clock: busy is never raised, so start may be
// held high every cycle. A load item writes one texel and gives no result.
// A shade item gives one result, marked by pixel_valid_o for exactly one
// cycle. The receiver cannot hold results off, and none is needed: the
// pipeline has no stall points. An item passes stage 1, stage 2, the
// texture row divider, which resolves one quotient bit per stage, the
// registered texture memory read and the output registers. Texels that
// were never loaded read as undefined colors. The user must write the
// configuration registers over the APB port only while no items are in
// flight; the core itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module textured_wall_column_pixel_core
  import twcol_pkg::*;
#(
  parameter int TEX_SIZE   = 64,
  parameter int MAX_SCREEN = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode_i,
  input  wire logic [13:0] texel_index_i,
  input  wire logic [23:0] texel_color_i,
  input  wire logic [9:0]  column_x_i,
  input  wire logic        hit_side_i,
  input  wire logic [25:0] wall_distance_i,
  input  wire logic signed [17:0] dir_x_i,
  input  wire logic signed [17:0] dir_y_i,
  input  wire logic [9:0]  screen_row_i,
  input  wire logic [15:0] slice_height_i,
  // Result channel
  output logic             pixel_valid_o,
  output logic [19:0]      pixel_address_o,
  output logic [23:0]      pixel_color_o
);

  localparam int TB    = $clog2(TEX_SIZE);
  localparam int AW    = 2 + 2 * TB;
  localparam int DEPTH = 4 * TEX_SIZE * TEX_SIZE;

  // Configuration registers.
  logic [25:0] player_x_q, player_y_q;
  logic [10:0] screen_w_q, screen_h_q;
  logic        cfg_we;
  logic [10:0] cfg_sat;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_we = psel && penable && pwrite;
  // Screen sizes above the supported maximum saturate; pwdata bits above bit 10 are ignored.
  assign cfg_sat = (32'(pwdata[10:0]) > MAX_SCREEN) ? 11'(MAX_SCREEN) : pwdata[10:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      screen_w_q <= 11'd640;
      screen_h_q <= 11'd480;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PLAYER_X: player_x_q <= pwdata[25:0];
        REG_PLAYER_Y: player_y_q <= pwdata[25:0];
        REG_SCREEN_W: screen_w_q <= cfg_sat;
        REG_SCREEN_H: screen_h_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PLAYER_X: prdata = {6'b0, player_x_q};
      REG_PLAYER_Y: prdata = {6'b0, player_y_q};
      REG_SCREEN_W: prdata = {21'b0, screen_w_q};
      REG_SCREEN_H: prdata = {21'b0, screen_h_q};
      default:      prdata = '0;
    endcase
  end

  // Stage 1: register the accepted item.
  logic        s1_v_q;
  logic        s1_op_q, s1_side_q;
  logic [13:0] s1_tidx_q;
  logic [23:0] s1_tcol_q;
  logic [9:0]  s1_col_q, s1_row_q;
  logic [25:0] s1_dist_q;
  logic signed [17:0] s1_dx_q, s1_dy_q;
  logic [15:0] s1_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q   <= opcode_i;
    s1_side_q <= hit_side_i;
    s1_tidx_q <= texel_index_i;
    s1_tcol_q <= texel_color_i;
    s1_col_q  <= column_x_i;
    s1_row_q  <= screen_row_i;
    s1_dist_q <= wall_distance_i;
    s1_dx_q   <= dir_x_i;
    s1_dy_q   <= dir_y_i;
    s1_h_q    <= (slice_height_i == 16'd0) ? 16'd1 : slice_height_i;
  end

  // Stage 1 logic: wall hit product and texture row offset.
  logic signed [17:0] s1_dir;
  logic signed [44:0] s1_prod;
  logic signed [25:0] s1_d;
  logic               s1_mirror;
  logic [1:0]         s1_tex;

  assign s1_dir  = s1_side_q ? s1_dx_q : s1_dy_q;
  assign s1_prod = $signed({1'b0, s1_dist_q}) * s1_dir;
  assign s1_d    = $signed({8'b0, s1_row_q, 8'b0})
                 - $signed({8'b0, s1_h_q[15:0] == 16'd0 ? 11'd0 : screen_h_q, 7'b0})
                 + $signed({3'b0, s1_h_q, 7'b0});
  assign s1_mirror = (!s1_side_q && (s1_dx_q > 18'sd0)) || (s1_side_q && s1_dy_q[17]);

  always_comb begin
    if (!s1_side_q && s1_dx_q[17]) begin
      s1_tex = TEX_NORTH;
    end else if (!s1_side_q && (s1_dx_q > 18'sd0)) begin
      s1_tex = TEX_SOUTH;
    end else if (s1_side_q && s1_dy_q[17]) begin
      s1_tex = TEX_WEST;
    end else begin
      s1_tex = TEX_EAST;
    end
  end

  // Stage 2: product slice registered, then texture column.
  logic        s2_v_q;
  item_t       s2_it_q;
  logic [15:0] s2_pfrac_q;
  logic        s2_mirror_q;
  logic signed [25:0] s2_d_q;
  logic [15:0] s2_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_it_q.op     <= s1_op_q;
    s2_it_q.side   <= s1_side_q;
    s2_it_q.tex    <= s1_tex;
    s2_it_q.tx     <= '0;
    s2_it_q.tidx   <= s1_tidx_q;
    s2_it_q.tcolor <= s1_tcol_q;
    s2_it_q.row    <= s1_row_q;
    s2_it_q.col    <= s1_col_q;
    s2_pfrac_q     <= s1_prod[31:16];
    s2_mirror_q    <= s1_mirror;
    s2_d_q         <= s1_d;
    s2_h_q         <= s1_h_q;
  end

  logic [15:0]   s2_base;
  logic [15:0]   s2_frac;
  logic [TB-1:0] s2_tx;
  item_t         s2_it;

  assign s2_base = s2_it_q.side ? player_x_q[15:0] : player_y_q[15:0];
  assign s2_frac = s2_base + s2_pfrac_q;
  assign s2_tx   = s2_mirror_q ? ~s2_frac[15 -: TB] : s2_frac[15 -: TB];

  always_comb begin
    s2_it    = s2_it_q;
    s2_it.tx = 8'(s2_tx);
  end

  // Texture row divider.
  logic          dv_v;
  item_t         dv_it;
  logic [TB-1:0] dv_ty;

  twcol_div #(.TB(TB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_v_q),
    .item_i  (s2_it),
    .d_i     (s2_d_q),
    .h_i     (s2_h_q),
    .valid_o (dv_v),
    .item_o  (dv_it),
    .ty_o    (dv_ty)
  );

  // Texture memory: loads write and pixels read at the same stage, so
  // program order is kept without forwarding.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [23:0]   ram_rdata;

  assign ram_we    = dv_v && (dv_it.op == OP_LOAD) && (32'(dv_it.tidx) < DEPTH);
  assign ram_re    = dv_v && (dv_it.op == OP_SHADE);
  assign ram_waddr = AW'(dv_it.tidx);
  assign ram_raddr = {dv_it.tex, dv_ty, dv_it.tx[TB-1:0]};

  twcol_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (dv_it.tcolor),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read stage: frame buffer address alongside the texel read.
  logic        rd_v_q;
  logic        rd_side_q;
  logic [19:0] rd_addr_q;
  logic [20:0] rd_prod;

  assign rd_prod = dv_it.row * screen_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_side_q <= dv_it.side;
    rd_addr_q <= rd_prod[19:0] + {10'b0, dv_it.col};
  end

  // Output registers; y-side hits are darkened by halving each channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_o <= 1'b0;
    end else begin
      pixel_valid_o <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_address_o <= rd_addr_q;
    pixel_color_o   <= rd_side_q ? ((ram_rdata >> 1) & HALF_MASK) : ram_rdata;
  end

  // A result follows only a texture read, through the read stage and output registers.
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> $past(ram_re, 2))
    else $error("result without a texture read");

  // The memory port is never asked to read and write in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("texture read and write in one cycle");

  // Every item that enters the divider leaves it valid at its output.
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> ##(TB+1) dv_v)
    else $error("divider lost an item");

endmodule

`default_nettype wire
